// ----- src/aid_pkg.sv -----
package aid_pkg;

    localparam int ACCEL_W = 16;
    localparam int SUM_W   = 2 * ACCEL_W;
    localparam int CNT_W   = $clog2(ACCEL_W);
    localparam int MAG_W   = 16;
    localparam int FIELD_W = 16;
    localparam int CFG_W   = 16;
    localparam int QCNT_W  = 4;

    localparam logic [MAG_W-1:0]  MAG_MAX          = '1;
    localparam logic [QCNT_W-1:0] QCNT_MAX         = '1;
    localparam logic [CFG_W-1:0]  RST_DELTA_THR    = 16'd737;
    localparam logic [CFG_W-1:0]  RST_JUMP_THR     = 16'd492;
    localparam logic [QCNT_W-1:0] RST_REQ_COUNT    = 4'd2;
    localparam logic [CFG_W-1:0]  RST_COOLDOWN_SEC = 16'd60;
    localparam logic [CFG_W-1:0]  RST_ONE_G        = 16'd4096;
    localparam logic [MAG_W-1:0]  RST_PREV_MAG     = 16'd4096;

    typedef enum logic [2:0] {
        CFG_DELTA_THR    = 3'd0,
        CFG_JUMP_THR     = 3'd1,
        CFG_REQ_COUNT    = 3'd2,
        CFG_COOLDOWN_SEC = 3'd3,
        CFG_ONE_G        = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

endpackage

// ----- src/accel_impact_detector_top.sv -----
// channel | direction | handshake                 | payload
// in      | input     | i_in_valid / o_in_stall   | operation, accel_x, accel_y, accel_z
// out     | output    | o_out_valid / i_out_stall | magnitude, deviation, jump, flags
// cfg     | input     | i_cfg_we                  | i_cfg_addr, i_cfg_data
// a sample goes in order through taking the word, the bit-serial squares, the
// bit-a-cycle square root, handing the root over and the decision (ST_DIFF, ST_OUT)
// a tick goes straight from ST_IDLE to ST_OUT; one item is in flight at a time
// reset is synchronous, active low, and restores register and history defaults
// a result waits in the output register under stall; the next word is taken meanwhile
module accel_impact_detector_top
    import aid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [FIELD_W-1:0] i_accel_x,
    input  logic [FIELD_W-1:0] i_accel_y,
    input  logic [FIELD_W-1:0] i_accel_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [MAG_W-1:0]   o_magnitude,
    output logic [MAG_W-1:0]   o_deviation,
    output logic [MAG_W-1:0]   o_jump,
    output logic               o_alert,
    output logic               o_suppressed,
    output logic               o_in_cooldown,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_addr,
    input  logic [CFG_W-1:0]   i_cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAIT_MAG,
        ST_DIFF,
        ST_OUT
    } t_state;

    t_state              r_state;
    logic                r_is_tick;
    logic [MAG_W-1:0]    r_mag, r_dev, r_jmp;
    logic [MAG_W-1:0]    r_prev_mag;
    logic                r_first;
    logic [QCNT_W-1:0]   r_qcnt;
    logic [CFG_W-1:0]    r_cooldown;
    logic                r_out_valid;
    logic [MAG_W-1:0]    r_o_mag, r_o_dev, r_o_jmp;
    logic                r_o_alert, r_o_supp, r_o_cool;

    logic [CFG_W-1:0]    r_delta_thr, r_jump_thr, r_cool_sec, r_one_g;
    logic [QCNT_W-1:0]   r_req_cnt;

    logic                in_acc, out_free, mag_start, mag_done;
    logic [MAG_W-1:0]    mag_val;
    logic                n_qual;
    logic [QCNT_W-1:0]   n_qcnt;
    logic [CFG_W-1:0]    n_cooldown;
    logic                n_alert, n_supp;

    aid_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mag_start),
        .i_x     (i_accel_x),
        .i_y     (i_accel_y),
        .i_z     (i_accel_z),
        .o_done  (mag_done),
        .o_mag   (mag_val)
    );

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && (r_state == ST_IDLE);
    assign mag_start  = in_acc && (t_op'(i_operation) == OP_SAMPLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_qual = (r_dev >= r_delta_thr) && (r_jmp >= r_jump_thr);
        n_qcnt = r_qcnt;
        n_cooldown = r_cooldown;
        n_alert = 1'b0;
        n_supp = 1'b0;
        if (r_is_tick) begin
            if (r_cooldown != '0) begin
                n_cooldown = r_cooldown - 1'b1;
            end
        end else begin
            if (n_qual) begin
                if (r_qcnt != QCNT_MAX) begin
                    n_qcnt = r_qcnt + 1'b1;
                end
            end else begin
                n_qcnt = '0;
            end
            if (n_qcnt >= r_req_cnt) begin
                n_qcnt = '0;
                if (r_cooldown != '0) begin
                    n_supp = 1'b1;
                end else begin
                    n_alert = 1'b1;
                    n_cooldown = r_cool_sec;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delta_thr <= RST_DELTA_THR;
            r_jump_thr  <= RST_JUMP_THR;
            r_req_cnt   <= RST_REQ_COUNT;
            r_cool_sec  <= RST_COOLDOWN_SEC;
            r_one_g     <= RST_ONE_G;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_DELTA_THR:    r_delta_thr <= i_cfg_data;
                CFG_JUMP_THR:     r_jump_thr  <= i_cfg_data;
                CFG_REQ_COUNT:    r_req_cnt   <= i_cfg_data[QCNT_W-1:0];
                CFG_COOLDOWN_SEC: r_cool_sec  <= i_cfg_data;
                CFG_ONE_G:        r_one_g     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_is_tick   <= 1'b0;
            r_prev_mag  <= RST_PREV_MAG;
            r_first     <= 1'b1;
            r_qcnt      <= '0;
            r_cooldown  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_is_tick <= (t_op'(i_operation) == OP_TICK);
                        if (t_op'(i_operation) == OP_TICK) begin
                            r_mag <= '0;
                            r_dev <= '0;
                            r_jmp <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_state <= ST_WAIT_MAG;
                        end
                    end
                end
                ST_WAIT_MAG: begin
                    if (mag_done) begin
                        r_mag <= mag_val;
                        r_state <= ST_DIFF;
                    end
                end
                ST_DIFF: begin
                    r_dev <= (r_mag >= r_one_g) ? r_mag - r_one_g : r_one_g - r_mag;
                    if (r_first) begin
                        r_jmp <= '0;
                    end else begin
                        r_jmp <= (r_mag >= r_prev_mag) ? r_mag - r_prev_mag
                                                       : r_prev_mag - r_mag;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_qcnt      <= n_qcnt;
                        r_cooldown  <= n_cooldown;
                        r_out_valid <= 1'b1;
                        r_o_mag     <= r_mag;
                        r_o_dev     <= r_dev;
                        r_o_jmp     <= r_jmp;
                        r_o_alert   <= n_alert;
                        r_o_supp    <= n_supp;
                        r_o_cool    <= (n_cooldown != '0);
                        if (!r_is_tick) begin
                            r_prev_mag <= r_mag;
                            r_first    <= 1'b0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_magnitude   = r_o_mag;
    assign o_deviation   = r_o_dev;
    assign o_jump        = r_o_jmp;
    assign o_alert       = r_o_alert;
    assign o_suppressed  = r_o_supp;
    assign o_in_cooldown = r_o_cool;

endmodule

// ----- src/aid_mag.sv -----
module aid_mag
    import aid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [FIELD_W-1:0] i_x,
    input  logic [FIELD_W-1:0] i_y,
    input  logic [FIELD_W-1:0] i_z,
    output logic               o_done,
    output logic [MAG_W-1:0]   o_mag
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [ACCEL_W-1:0]   r_ax, r_ay, r_az;
    logic [SUM_W-1:0]     r_mx, r_my, r_mz;
    logic [SUM_W-1:0]     r_sum;
    logic [ACCEL_W+1:0]   r_rem;
    logic [ACCEL_W-1:0]   r_root;

    logic [ACCEL_W-1:0]   n_ax, n_ay, n_az;
    logic [SUM_W-1:0]     n_acc;
    logic [ACCEL_W+1:0]   n_rem_sh, n_trial;
    logic [31:0]          n_root_ext;

    function automatic logic [ACCEL_W-1:0] abs_of(input logic [FIELD_W-1:0] raw);
        logic [31:0]        ext;
        logic [ACCEL_W-1:0] v;
        ext = {16'b0, raw};
        v = ext[ACCEL_W-1:0];
        return v[ACCEL_W-1] ? (~v + 1'b1) : v;
    endfunction

    always_comb begin
        n_ax = abs_of(i_x);
        n_ay = abs_of(i_y);
        n_az = abs_of(i_z);
        n_acc = r_sum + (r_ax[0] ? r_mx : '0) + (r_ay[0] ? r_my : '0)
              + (r_az[0] ? r_mz : '0);
        n_rem_sh = {r_rem[ACCEL_W-1:0], r_sum[SUM_W-1 -: 2]};
        n_trial = {r_root, 2'b01};
        n_root_ext = 32'(r_root);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_ax <= n_ax;
                        r_ay <= n_ay;
                        r_az <= n_az;
                        r_mx <= SUM_W'(n_ax);
                        r_my <= SUM_W'(n_ay);
                        r_mz <= SUM_W'(n_az);
                        r_sum <= '0;
                        r_cnt <= '0;
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_sum <= n_acc;
                    r_ax <= r_ax >> 1;
                    r_ay <= r_ay >> 1;
                    r_az <= r_az >> 1;
                    r_mx <= r_mx << 1;
                    r_my <= r_my << 1;
                    r_mz <= r_mz << 1;
                    if (r_cnt == CNT_W'(ACCEL_W - 1)) begin
                        r_cnt <= '0;
                        r_rem <= '0;
                        r_root <= '0;
                        r_state <= S_ROOT;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ROOT: begin
                    r_sum <= r_sum << 2;
                    if (n_rem_sh >= n_trial) begin
                        r_rem <= n_rem_sh - n_trial;
                        r_root <= {r_root[ACCEL_W-2:0], 1'b1};
                    end else begin
                        r_rem <= n_rem_sh;
                        r_root <= {r_root[ACCEL_W-2:0], 1'b0};
                    end
                    if (r_cnt == CNT_W'(ACCEL_W - 1)) begin
                        r_cnt <= '0;
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // root saturates at the magnitude width
    assign o_done = (r_state == S_DONE);
    assign o_mag  = (|n_root_ext[31:MAG_W]) ? MAG_MAX : n_root_ext[MAG_W-1:0];

endmodule

// ----- src/aid_checker.sv -----
module aid_checker
    import aid_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [MAG_W-1:0]   o_magnitude,
    input logic               o_alert,
    input logic               o_suppressed,
    input logic               o_in_cooldown
);

    // result word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_magnitude))
        else $error("output word dropped or changed under stall");

    // one word in flight: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again before the word was handled");

    a_alert_xor_supp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_alert && o_suppressed))
        else $error("alert and suppressed on the same word");

    // suppression only while cooldown runs, and a sample does not count it down
    a_supp_cooldown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_suppressed |-> o_in_cooldown)
        else $error("suppressed word outside cooldown");

endmodule

bind accel_impact_detector_top aid_checker u_aid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_magnitude   (o_magnitude),
    .o_alert       (o_alert),
    .o_suppressed  (o_suppressed),
    .o_in_cooldown (o_in_cooldown)
);
